/* sv/cts_pkg.sv */
// shared types, constants and tag tables for the colour tag substituter
// no dependencies; imported by cts_ctrl, cts_dp and the top level
`timescale 1ns / 1ps

package cts_pkg;

    localparam int DEF_MAX_TAG_LEN = 10;
    localparam int TAG_COUNT       = 12;
    localparam int TAG_BODY_MAX    = 8;   // longest tag without its closing bracket
    localparam int CODE_MAX        = 11;  // longest escape sequence
    localparam int CODE_IDX_W      = 4;

    localparam logic [7:0] OPEN_CHAR  = 8'h5B;
    localparam logic [7:0] CLOSE_CHAR = 8'h5D;
    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] PAD_CHAR   = 8'h00;

    typedef enum logic [3:0] {
        TAG_BLACK, TAG_RED, TAG_GREEN, TAG_YELLOW, TAG_BLUE, TAG_MAGENTA,
        TAG_CYAN, TAG_WHITE, TAG_ORANGE, TAG_PINK, TAG_BROWN, TAG_PURPLE
    } t_tag;

    typedef enum logic [2:0] {
        S_IDLE, S_FLUSH, S_LOAD, S_DRAIN, S_CODE, S_CHAR
    } t_state;

    typedef enum logic [1:0] {
        SRC_HELD, SRC_CODE, SRC_CHAR
    } t_src;

    typedef struct packed {
        logic accept;
        logic append;
        logic load_open;
        logic emit;
        t_src src;
        logic last;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic near_full;
        logic in_open;
        logic in_close;
        logic in_end;
        logic match_hit;
        logic item_open;
        logic item_end;
        logic code_last;
        logic out_free;
    } t_dp_stat;

    // held length of each tag, opening bracket included, closing bracket excluded
    function automatic logic [3:0] tag_len(input t_tag t);
        logic [3:0] len;
        case (t)
            TAG_BLACK:   len = 4'd6;
            TAG_RED:     len = 4'd4;
            TAG_GREEN:   len = 4'd6;
            TAG_YELLOW:  len = 4'd7;
            TAG_BLUE:    len = 4'd5;
            TAG_MAGENTA: len = 4'd8;
            TAG_CYAN:    len = 4'd5;
            TAG_WHITE:   len = 4'd6;
            TAG_ORANGE:  len = 4'd7;
            TAG_PINK:    len = 4'd5;
            TAG_BROWN:   len = 4'd6;
            TAG_PURPLE:  len = 4'd7;
            default:     len = 4'd15;
        endcase
        return len;
    endfunction

    // first character in the top byte
    function automatic logic [8*TAG_BODY_MAX-1:0] tag_name(input t_tag t);
        logic [8*TAG_BODY_MAX-1:0] nm;
        case (t)
            TAG_BLACK:   nm = {"[BLACK", {2{PAD_CHAR}}};
            TAG_RED:     nm = {"[RED", {4{PAD_CHAR}}};
            TAG_GREEN:   nm = {"[GREEN", {2{PAD_CHAR}}};
            TAG_YELLOW:  nm = {"[YELLOW", PAD_CHAR};
            TAG_BLUE:    nm = {"[BLUE", {3{PAD_CHAR}}};
            TAG_MAGENTA: nm = {"[MAGENTA"};
            TAG_CYAN:    nm = {"[CYAN", {3{PAD_CHAR}}};
            TAG_WHITE:   nm = {"[WHITE", {2{PAD_CHAR}}};
            TAG_ORANGE:  nm = {"[ORANGE", PAD_CHAR};
            TAG_PINK:    nm = {"[PINK", {3{PAD_CHAR}}};
            TAG_BROWN:   nm = {"[BROWN", {2{PAD_CHAR}}};
            TAG_PURPLE:  nm = {"[PURPLE", PAD_CHAR};
            default:     nm = '0;
        endcase
        return nm;
    endfunction

    function automatic logic [7:0] tag_char(input t_tag t, input logic [2:0] pos);
        logic [8*TAG_BODY_MAX-1:0] nm;
        int ofs;
        nm  = tag_name(t);
        ofs = 8 * (TAG_BODY_MAX - 1 - int'(pos));
        return nm[ofs +: 8];
    endfunction

    function automatic logic [CODE_IDX_W-1:0] code_len(input t_tag t);
        logic [CODE_IDX_W-1:0] len;
        case (t)
            TAG_ORANGE, TAG_PINK: len = CODE_IDX_W'(11);
            TAG_BROWN:            len = CODE_IDX_W'(10);
            default:              len = CODE_IDX_W'(5);
        endcase
        return len;
    endfunction

    function automatic logic [8*CODE_MAX-1:0] code_str(input t_tag t);
        logic [8*CODE_MAX-1:0] cs;
        case (t)
            TAG_BLACK:   cs = {ESC_CHAR, "[30m", {6{PAD_CHAR}}};
            TAG_RED:     cs = {ESC_CHAR, "[91m", {6{PAD_CHAR}}};
            TAG_GREEN:   cs = {ESC_CHAR, "[92m", {6{PAD_CHAR}}};
            TAG_YELLOW:  cs = {ESC_CHAR, "[93m", {6{PAD_CHAR}}};
            TAG_BLUE:    cs = {ESC_CHAR, "[94m", {6{PAD_CHAR}}};
            TAG_MAGENTA: cs = {ESC_CHAR, "[95m", {6{PAD_CHAR}}};
            TAG_CYAN:    cs = {ESC_CHAR, "[96m", {6{PAD_CHAR}}};
            TAG_WHITE:   cs = {ESC_CHAR, "[97m", {6{PAD_CHAR}}};
            TAG_ORANGE:  cs = {ESC_CHAR, "[38;5;208m"};
            TAG_PINK:    cs = {ESC_CHAR, "[38;5;212m"};
            TAG_BROWN:   cs = {ESC_CHAR, "[38;5;94m", PAD_CHAR};
            TAG_PURPLE:  cs = {ESC_CHAR, "[35m", {6{PAD_CHAR}}};
            default:     cs = '0;
        endcase
        return cs;
    endfunction

    function automatic logic [7:0] code_char(input t_tag t, input logic [CODE_IDX_W-1:0] k);
        logic [8*CODE_MAX-1:0] cs;
        int ofs;
        cs  = code_str(t);
        ofs = 8 * (CODE_MAX - 1 - int'(k));
        if (ofs < 0) begin
            ofs = 0;
        end
        return cs[ofs +: 8];
    endfunction

endpackage

/* sv/cts_ctrl.sv */
// sequencing state machine for the colour tag substituter
// depends on cts_pkg; drives cts_dp through t_dp_cmd, watches t_dp_stat
`timescale 1ns / 1ps

module cts_ctrl
    import cts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_open) begin
                        if (!i_stat.cnt_zero) begin
                            n_state = S_FLUSH;
                        end else if (i_stat.in_end) begin
                            n_state = S_DRAIN;
                        end
                    end else if (i_stat.cnt_zero) begin
                        n_state = S_CHAR;
                    end else if (i_stat.in_close) begin
                        n_state = i_stat.match_hit ? S_CODE : S_FLUSH;
                    end else if (i_stat.near_full || i_stat.in_end) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free && i_stat.cnt_one) begin
                    n_state = i_stat.item_open ? S_LOAD : S_CHAR;
                end
            end
            S_LOAD: begin
                n_state = i_stat.item_end ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                if (i_stat.out_free && i_stat.cnt_one) begin
                    n_state = S_IDLE;
                end
            end
            S_CODE: begin
                if (i_stat.out_free && i_stat.code_last) begin
                    n_state = S_IDLE;
                end
            end
            S_CHAR: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.src  = SRC_HELD;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.load_open = i_stat.in_open && i_stat.cnt_zero;
                    o_cmd.append    = !i_stat.in_open && !i_stat.in_close
                                      && !i_stat.cnt_zero;
                end
            end
            S_FLUSH: begin
                o_cmd.emit = i_stat.out_free;
                // a later beat follows unless this opens a run with no end flag
                o_cmd.last = i_stat.cnt_one && i_stat.item_open && !i_stat.item_end;
            end
            S_LOAD: begin
                o_cmd.load_open = 1'b1;
            end
            S_DRAIN: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.last = i_stat.cnt_one;
            end
            S_CODE: begin
                o_cmd.emit  = i_stat.out_free;
                o_cmd.src   = SRC_CODE;
                o_cmd.last  = i_stat.code_last;
                o_cmd.clear = i_stat.out_free && i_stat.code_last;
            end
            S_CHAR: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.src  = SRC_CHAR;
                o_cmd.last = 1'b1;
            end
        endcase
    end

endmodule

/* sv/cts_dp.sv */
// datapath: held character shift line, tag matcher, code counter, output register
// depends on cts_pkg; commanded by cts_ctrl
`timescale 1ns / 1ps

module cts_dp
    import cts_pkg::*;
#(
    parameter int MAX_TAG_LEN = DEF_MAX_TAG_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_out_valid,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat
);

    localparam int IW = $clog2(MAX_TAG_LEN);
    localparam int CW = $clog2(MAX_TAG_LEN + 1);

    logic [7:0]            r_held [MAX_TAG_LEN];
    logic [CW-1:0]         r_count;
    logic [7:0]            r_ch;
    logic                  r_end;
    t_tag                  r_tag;
    logic [CODE_IDX_W-1:0] r_code_idx;
    logic [7:0]            r_out_char;
    logic                  r_out_last;
    logic                  r_out_valid;

    logic                  w_hit;
    t_tag                  w_tag;
    logic                  w_out_free;
    logic                  w_pop;
    logic [7:0]            w_src_char;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_pop      = i_cmd.emit && (i_cmd.src == SRC_HELD);

    // compare the held run against every tag body
    always_comb begin
        logic ok;
        w_hit = 1'b0;
        w_tag = TAG_BLACK;
        for (int t = TAG_COUNT - 1; t >= 0; t--) begin
            ok = (r_count == CW'(tag_len(t_tag'(t))));
            for (int i = 0; i < TAG_BODY_MAX; i++) begin
                if ((i < int'(tag_len(t_tag'(t))))
                    && (r_held[i] != tag_char(t_tag'(t), 3'(i)))) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                w_hit = 1'b1;
                w_tag = t_tag'(t);
            end
        end
    end

    // held run: pops from the front while flushing
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            for (int i = 0; i < MAX_TAG_LEN - 1; i++) begin
                r_held[i] <= r_held[i+1];
            end
        end else if (i_cmd.append) begin
            r_held[r_count[IW-1:0]] <= i_text_char;
        end else if (i_cmd.load_open) begin
            r_held[0] <= OPEN_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_pop) begin
            r_count <= r_count - CW'(1);
        end else if (i_cmd.append) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.load_open) begin
            r_count <= CW'(1);
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end
    end

    // item capture and escape sequence position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch       <= i_text_char;
            r_end      <= i_end_of_text;
            r_tag      <= w_tag;
            r_code_idx <= '0;
        end else if (i_cmd.emit && (i_cmd.src == SRC_CODE)) begin
            r_code_idx <= r_code_idx + CODE_IDX_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.src)
            SRC_HELD: w_src_char = r_held[0];
            SRC_CODE: w_src_char = code_char(r_tag, r_code_idx);
            SRC_CHAR: w_src_char = r_ch;
            default:  w_src_char = r_ch;
        endcase
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= w_src_char;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;
    assign o_out_valid   = r_out_valid;

    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.cnt_one   = (r_count == CW'(1));
    assign o_stat.near_full = (r_count == CW'(MAX_TAG_LEN - 1));
    assign o_stat.in_open   = (i_text_char == OPEN_CHAR);
    assign o_stat.in_close  = (i_text_char == CLOSE_CHAR);
    assign o_stat.in_end    = i_end_of_text;
    assign o_stat.match_hit = w_hit;
    assign o_stat.item_open = (r_ch == OPEN_CHAR);
    assign o_stat.item_end  = r_end;
    assign o_stat.code_last = (r_code_idx == code_len(r_tag) - CODE_IDX_W'(1));
    assign o_stat.out_free  = w_out_free;

endmodule

/* sv/colour_tag_substituter.sv */
// colour tag substituter: one character per input beat, up to max(11, MAX_TAG_LEN) result beats.
// a plain character is captured in the item register and then moved to the output register;
// results come one per cycle, while the output is free, from the held-character shift line or
// the code table; a new bracket that follows a flush is loaded after the flush. input is
// taken only between items.
// reset: synchronous active low, clears state, held count and output valid.
`timescale 1ns / 1ps

module colour_tag_substituter
    import cts_pkg::*;
#(
    parameter int MAX_TAG_LEN = DEF_MAX_TAG_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cts_dp #(
        .MAX_TAG_LEN (MAX_TAG_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run),
        .o_out_valid   (o_out_valid),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

endmodule

/* bench/colour_tag_substituter_test.sv */
// self-checking bench for colour_tag_substituter: queued text stimulus, random gaps and
// stalls on both channels, in-bench substitution predictor checked beat by beat
// depends on cts_pkg (bracket and escape characters, tag enum) and the block's top level
`timescale 1ns / 1ps

module colour_tag_substituter_test;
    import cts_pkg::*;

    localparam int HOLD_LIMIT  = DEF_MAX_TAG_LEN;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TARGET_CHARS = 450;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_text_beat;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_out_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_text_char   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_char;
    logic       o_last_of_run;

    t_text_beat pending_q[$];
    t_out_beat  expected_q[$];

    // predictor state
    logic [7:0] held_buf [HOLD_LIMIT];
    int         held_len = 0;

    int items_in   = 0;
    int beats_out  = 0;
    int tags_hit   = 0;
    int error_cnt  = 0;
    int cycle_cnt  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    string tag_txt [TAG_COUNT] = '{
        "[BLACK]", "[RED]", "[GREEN]", "[YELLOW]", "[BLUE]", "[MAGENTA]",
        "[CYAN]", "[WHITE]", "[ORANGE]", "[PINK]", "[BROWN]", "[PURPLE]"
    };
    // escape sequence after the leading ESC
    string esc_tail [TAG_COUNT] = '{
        "[30m", "[91m", "[92m", "[93m", "[94m", "[95m",
        "[96m", "[97m", "[38;5;208m", "[38;5;212m", "[38;5;94m", "[35m"
    };

    colour_tag_substituter #(
        .MAX_TAG_LEN(HOLD_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_text_char  (i_text_char),
        .i_end_of_text(i_end_of_text),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_char   (o_out_char),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void push_beat(logic [7:0] c);
        t_out_beat b;
        b.ch   = c;
        b.last = 1'b0;
        expected_q.push_back(b);
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < held_len; k++) begin
            push_beat(held_buf[k]);
        end
        held_len = 0;
    endfunction

    // tag equal to the held run plus a closing bracket, or -1
    function automatic int find_tag();
        string s;
        bit    same;
        for (int t = 0; t < TAG_COUNT; t++) begin
            s = tag_txt[t];
            if (s.len() == held_len + 1) begin
                same = 1'b1;
                for (int k = 0; k < held_len; k++) begin
                    if (s[k] != held_buf[k]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    return t;
                end
            end
        end
        return -1;
    endfunction

    function automatic void predict_substitution(logic [7:0] c, logic eot);
        int    first;
        int    t;
        string code;
        first = expected_q.size();
        if (c == OPEN_CHAR) begin
            flush_held();
            held_buf[0] = c;
            held_len    = 1;
        end else if (c == CLOSE_CHAR && held_len > 0) begin
            t = find_tag();
            if (t >= 0) begin
                push_beat(ESC_CHAR);
                code = esc_tail[t];
                for (int k = 0; k < code.len(); k++) begin
                    push_beat(code[k]);
                end
                held_len = 0;
                tags_hit++;
            end else begin
                flush_held();
                push_beat(c);
            end
        end else if (held_len > 0) begin
            if (held_len < HOLD_LIMIT) begin
                held_buf[held_len] = c;
                held_len++;
            end
            // too long to be a tag
            if (held_len >= HOLD_LIMIT) begin
                flush_held();
            end
        end else begin
            push_beat(c);
        end
        if (eot) begin
            flush_held();
        end
        if (expected_q.size() > first) begin
            expected_q[expected_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void add_char(logic [7:0] c, logic eot);
        t_text_beat b;
        b.ch  = c;
        b.eot = eot;
        pending_q.push_back(b);
    endfunction

    function automatic void add_text(string s, logic eot_on_last);
        for (int k = 0; k < s.len(); k++) begin
            add_char(s[k], eot_on_last && (k == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'(8'h41 + $urandom_range(0, 25));
    endfunction

    function automatic logic rand_eot();
        return ($urandom_range(0, 99) < 4);
    endfunction

    // one stretch of random text: mostly well-formed tags, some broken ones and noise
    function automatic void add_random_segment();
        t_tag  tg;
        string s;
        int    kind;
        int    pos;
        int    n;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        tg   = t_tag'($urandom_range(0, TAG_COUNT - 1));
        s    = tag_txt[int'(tg)];
        if (kind < 50) begin
            for (int k = 0; k < s.len() - 1; k++) begin
                add_char(s[k], rand_eot());
            end
            add_char(CLOSE_CHAR, $urandom_range(0, 99) < 15);
        end else if (kind < 65) begin
            case ($urandom_range(0, 2))
                0: begin
                    pos    = $urandom_range(1, s.len() - 2);
                    s[pos] = rand_letter();
                    add_text(s, 1'($urandom_range(0, 1)));
                end
                1: begin
                    // closing bracket never comes
                    for (int k = 0; k < s.len() - 1; k++) begin
                        add_char(s[k], 1'b0);
                    end
                end
                default: begin
                    for (int k = 0; k < s.len() - 1; k++) begin
                        add_char(s[k], 1'b0);
                    end
                    add_char(rand_letter(), 1'b0);
                    add_char(CLOSE_CHAR, rand_eot());
                end
            endcase
        end else if (kind < 75) begin
            add_char(OPEN_CHAR, 1'b0);
            n = $urandom_range(7, 13);
            for (int k = 0; k < n; k++) begin
                add_char(rand_letter(), rand_eot());
            end
        end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(0, 7))
                    0:       c = OPEN_CHAR;
                    1:       c = CLOSE_CHAR;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                add_char(c, rand_eot());
            end
        end
    endfunction

    function automatic bit noisy_phase();
        return !(items_in >= 200 && items_in < 300);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_q.size() != 0 && !(noisy_phase() && $urandom_range(0, 99) < 20)) begin
                i_in_valid    <= 1'b1;
                i_text_char   <= pending_q[0].ch;
                i_end_of_text <= pending_q[0].eot;
                void'(pending_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && items_in >= 60) begin
            i_out_ready <= 1'b0;
            hold_left   <= 300;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= !(noisy_phase() && $urandom_range(0, 99) < 20);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin : beat_monitor
        t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_substitution(i_text_char, i_end_of_text);
                items_in <= items_in + 1;
            end
            if (o_out_valid && i_out_ready) begin
                beats_out <= beats_out + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected beat char %02h last %0b", $time,
                             o_out_char, o_last_of_run);
                    error_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_char !== want.ch) begin
                        $display("%0t: out_char mismatch: expected %02h, got %02h", $time,
                                 want.ch, o_out_char);
                        error_cnt++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run mismatch: expected %0b, got %0b", $time,
                                 want.last, o_last_of_run);
                        error_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // directed: lone closing bracket with end flag, a tag, new bracket while holding,
        // unmatched close, run too long (carrying 00 and ff), end flag on a held run
        add_char(CLOSE_CHAR, 1'b1);
        add_text("[RED]", 1'b0);
        add_text("[ab[", 1'b0);
        add_text("x]", 1'b0);
        add_char(OPEN_CHAR, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_text("ABCDEFG", 1'b0);
        add_text("[Q", 1'b1);
        while (pending_q.size() < TARGET_CHARS) begin
            add_random_segment();
        end
        add_char(rand_letter(), 1'b1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("run covered %0d text beats and %0d output beats, %0d colour tags replaced",
                 items_in, beats_out, tags_hit);
        $display("with flushes, overlong runs, end flags, random gaps and a long output stall");
        if (error_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
